>>> hw/rtl/lcg_pkg.sv
package lcg_pkg;

	// field widths
	localparam int SEED_W   = 31;
	localparam int PROD_W   = 2 * SEED_W;
	localparam int DECILE_W = 4;
	localparam int DEC_ACC_W = SEED_W + 4;
	localparam int CFG_W    = 32;
	localparam int ADDR_W   = 4;

	// default fraction width
	localparam int FRACTION_BITS_DEF = 16;

	// register reset values
	localparam logic [SEED_W-1:0] MULT_RST = SEED_W'(40);
	localparam logic [SEED_W-1:0] INC_RST  = SEED_W'(725);
	localparam logic [SEED_W-1:0] MOD_RST  = SEED_W'(729);
	localparam logic [SEED_W-1:0] SEED_RST = SEED_W'(1);

	// saturated decile
	localparam logic [DECILE_W-1:0] DECILE_SAT = DECILE_W'(9);

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MULT = 2'd0;
	localparam logic [1:0] REG_INC  = 2'd1;
	localparam logic [1:0] REG_MOD  = 2'd2;

	// request opcodes
	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_PREP,
		ST_FRAC,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/lcg_generator_with_fraction.sv
// advance request: a bit-serial shift-add multiply, then a restoring remainder, then the fraction division
// load request: only the fraction division, on the shared subtractor
// one request in flight, next taken the cycle after the result is registered,
// later while a result waits on m_tready
// async reset: seed 1, multiplier 40, increment 725, modulus 729, no result pending
module lcg_generator_with_fraction #(
	parameter int FRACTION_BITS = lcg_pkg::FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input request
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,   // load_value[30:0]
	input  logic s_tuser,          // opcode
	// result
	output logic m_tvalid,
	input  logic m_tready,
	// seed_out, fraction, decile, zero pad (lowest first)
	output logic [((lcg_pkg::SEED_W + FRACTION_BITS + lcg_pkg::DECILE_W + 7) / 8) * 8 - 1:0]
		m_tdata,
	// register port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [lcg_pkg::ADDR_W-1:0] paddr,
	input  logic [lcg_pkg::CFG_W-1:0] pwdata,
	output logic [lcg_pkg::CFG_W-1:0] prdata,
	output logic pready
);

	localparam int SW      = lcg_pkg::SEED_W;
	localparam int DW      = lcg_pkg::DECILE_W;
	localparam int AW      = lcg_pkg::DEC_ACC_W;
	localparam int OUT_W   = SW + FRACTION_BITS + DW;
	localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int MAX_STEPS = (lcg_pkg::PROD_W > FRACTION_BITS) ? lcg_pkg::PROD_W
		: FRACTION_BITS;
	localparam int CNT_W   = $clog2(MAX_STEPS);

	lcg_pkg::state_t state_q, state_d;

	logic [SW-1:0] mult_q, inc_q, mod_q;
	logic [SW-1:0] seed_q;
	logic [SW:0]   hi_q;
	logic [SW-1:0] lo_q;
	logic [SW:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [AW-1:0] dd_q, dv_q;
	logic [DW-1:0] dec_q;
	logic sat_q;

	logic [SW-1:0] out_seed_q;
	logic [FRACTION_BITS-1:0] out_frac_q;
	logic [DW-1:0] out_dec_q;
	logic out_valid_q;

	logic in_acc, cfg_wr, out_free, cnt_last;
	logic [SW+1:0] mul_sum;
	logic [SW:0]   rem_shift, rem_sub;
	logic          rem_ge, dec_ge;

	assign in_acc   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || m_tready;
	assign pready   = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= lcg_pkg::MULT_RST;
			inc_q  <= lcg_pkg::INC_RST;
			mod_q  <= lcg_pkg::MOD_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lcg_pkg::REG_MULT: mult_q <= pwdata[SW-1:0];
				lcg_pkg::REG_INC:  inc_q  <= pwdata[SW-1:0];
				lcg_pkg::REG_MOD:  mod_q  <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (paddr[3:2])
			lcg_pkg::REG_MULT: prdata = lcg_pkg::CFG_W'(mult_q);
			lcg_pkg::REG_INC:  prdata = lcg_pkg::CFG_W'(inc_q);
			lcg_pkg::REG_MOD:  prdata = lcg_pkg::CFG_W'(mod_q);
			default:           prdata = '0;
		endcase
	end

	// shift-add step: add multiplier when the low product bit is set
	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {2'b00, mult_q} : '0);

	// shared restoring subtractor: product bits in remainder phase, zeros in fraction phase
	assign rem_shift = {r_q[SW-1:0], (state_q == lcg_pkg::ST_MOD) ? hi_q[SW-1] : 1'b0};
	assign rem_ge    = rem_shift >= {1'b0, mod_q};
	assign rem_sub   = rem_shift - {1'b0, mod_q};

	// decile quotient digit
	assign dec_ge = dd_q >= dv_q;

	always_comb begin
		case (state_q)
			lcg_pkg::ST_MUL:  cnt_last = cnt_q == CNT_W'(SW - 1);
			lcg_pkg::ST_MOD:  cnt_last = cnt_q == CNT_W'(lcg_pkg::PROD_W - 1);
			lcg_pkg::ST_FRAC: cnt_last = cnt_q == CNT_W'(FRACTION_BITS - 1);
			default:          cnt_last = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			lcg_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == lcg_pkg::OP_LOAD) ? lcg_pkg::ST_PREP
						: lcg_pkg::ST_MUL;
				end
			end
			lcg_pkg::ST_MUL: begin
				if (cnt_last) state_d = lcg_pkg::ST_MOD;
			end
			lcg_pkg::ST_MOD: begin
				if (cnt_last) state_d = lcg_pkg::ST_PREP;
			end
			lcg_pkg::ST_PREP: begin
				state_d = lcg_pkg::ST_FRAC;
			end
			lcg_pkg::ST_FRAC: begin
				if (cnt_last) state_d = lcg_pkg::ST_DONE;
			end
			lcg_pkg::ST_DONE: begin
				if (out_free) state_d = lcg_pkg::ST_IDLE;
			end
			default: state_d = lcg_pkg::ST_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_last || state_q == lcg_pkg::ST_IDLE) begin
			cnt_q <= '0;
		end else if (state_q == lcg_pkg::ST_MUL || state_q == lcg_pkg::ST_MOD
			|| state_q == lcg_pkg::ST_FRAC) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= lcg_pkg::SEED_RST;
		end else if (in_acc && s_tuser == lcg_pkg::OP_LOAD) begin
			seed_q <= s_tdata[SW-1:0];
		end else if (state_q == lcg_pkg::ST_MOD && cnt_last) begin
			seed_q <= rem_ge ? rem_sub[SW-1:0] : rem_shift[SW-1:0];
		end
	end

	// product, remainder, fraction and decile datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lcg_pkg::ST_IDLE: begin
				// increment preloaded in the high half is added by the shift-add
				hi_q <= {1'b0, inc_q};
				lo_q <= seed_q;
				r_q  <= '0;
			end
			lcg_pkg::ST_MUL: begin
				hi_q <= mul_sum[SW+1:1];
				lo_q <= {mul_sum[0], lo_q[SW-1:1]};
			end
			lcg_pkg::ST_MOD: begin
				// product leaves msb first from bit 61
				hi_q <= {hi_q[SW-1:0], lo_q[SW-1]};
				lo_q <= {lo_q[SW-2:0], 1'b0};
				r_q  <= rem_ge ? rem_sub : rem_shift;
			end
			lcg_pkg::ST_PREP: begin
				r_q   <= {1'b0, seed_q};
				sat_q <= seed_q >= mod_q;
				dd_q  <= AW'({seed_q, 3'b000}) + AW'({seed_q, 1'b0});
				dv_q  <= AW'({mod_q, 3'b000});
				dec_q <= '0;
				quo_q <= '0;
			end
			lcg_pkg::ST_FRAC: begin
				r_q   <= rem_ge ? rem_sub : rem_shift;
				quo_q <= {quo_q[FRACTION_BITS-2:0], rem_ge};
				// four decile digits during the first fraction steps
				if (cnt_q < CNT_W'(DW)) begin
					dd_q  <= dec_ge ? dd_q - dv_q : dd_q;
					dv_q  <= dv_q >> 1;
					dec_q <= {dec_q[DW-2:0], dec_ge};
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lcg_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lcg_pkg::ST_DONE && out_free) begin
			out_seed_q <= seed_q;
			out_frac_q <= sat_q ? '1 : quo_q;
			out_dec_q  <= sat_q ? lcg_pkg::DECILE_SAT : dec_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'({out_dec_q, out_frac_q, out_seed_q});

	// an advance request starts the multiply
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == lcg_pkg::OP_ADVANCE) |=> state_q == lcg_pkg::ST_MUL)
		else $error("advance request did not start multiply");

	// the running remainder stays below a nonzero modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcg_pkg::ST_MOD && mod_q != '0) |-> r_q < {1'b0, mod_q})
		else $error("remainder out of range");

	// a result appears only after the sequencer finished
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == lcg_pkg::ST_DONE))
		else $error("result without finished request");

	// decile stays within the unit interval bins
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_dec_q <= lcg_pkg::DECILE_SAT)
		else $error("decile above saturation");

endmodule
